>>> hdl/ceus_pkg.sv
// shared types, register map and coefficient tables for the eq update sequencer
package ceus_pkg;

  // band count and widths
  localparam int BANDS       = 5;
  localparam int BAND_W      = $clog2(BANDS);
  localparam int GAIN_W      = 8;
  localparam int IDX_W       = 5;
  localparam int SCALE_DEPTH = 25;
  localparam int QUEUE_DEPTH = 2;

  // codec register map
  localparam logic [7:0] ADDR_PRIV_INDEX = 8'h6A;
  localparam logic [7:0] ADDR_PRIV_DATA  = 8'h6C;
  localparam logic [7:0] ADDR_CTRL1      = 8'hB0;
  localparam logic [7:0] ADDR_CTRL2      = 8'hB1;
  localparam logic [7:0] SLOT_BASE       = 8'hA1;
  localparam logic [7:0] SLOT_STRIDE     = 8'd3;

  // control register bits
  localparam logic [15:0] BIT_LATCH   = 16'h4000;
  localparam logic [15:0] BIT_ADC_SRC = 16'h8000;
  localparam logic [15:0] BIT_LP_TYPE = 16'h0080;
  localparam logic [15:0] STAGE_BITS  = 16'h001F;

  // gain clamp limits
  localparam logic signed [GAIN_W-1:0] GAIN_MIN = -8'sd12;
  localparam logic signed [GAIN_W-1:0] GAIN_MAX = 8'sd12;

  // band with the reference neutral value (coefficient equals the table entry)
  localparam logic [BAND_W-1:0] REF_BAND = 3'd1;

  // per-dB scale, reference neutral 0x1D2C
  localparam logic [15:0] DB_SCALE [SCALE_DEPTH] = '{
    16'd1876,  16'd2105,  16'd2362,  16'd2650,  16'd2973,  16'd3336,  16'd3743,
    16'd4200,  16'd4712,  16'd5287,  16'd5932,  16'd6656,  16'd7468,  16'd8379,
    16'd9402,  16'd10549, 16'd11836, 16'd13280, 16'd14901, 16'd16719, 16'd18759,
    16'd21048, 16'd23616, 16'd26497, 16'd29731
  };

  // same scale for neutral 0x01F4: (500 * scale + 0x1D2C / 2) / 0x1D2C, rounded
  localparam logic [15:0] DB_SCALE_LOW [SCALE_DEPTH] = '{
    16'd126,  16'd141,  16'd158,  16'd177,  16'd199,  16'd223,  16'd251,
    16'd281,  16'd315,  16'd354,  16'd397,  16'd446,  16'd500,  16'd561,
    16'd629,  16'd706,  16'd792,  16'd889,  16'd998,  16'd1119, 16'd1256,
    16'd1409, 16'd1581, 16'd1774, 16'd1991
  };

  // one queued job: what the sequencer has to write for one request
  typedef struct packed {
    logic                          disable_eq;
    logic                          activate;
    logic [BANDS-1:0]              band_mask;
    logic [BANDS-1:0][IDX_W-1:0]   scale_idx;
    logic [15:0]                   ctrl1;
    logic [15:0]                   ctrl2;
  } ceus_job_t;

  // clamp a raw gain to -12..12 and turn it into a table index 0..24
  function automatic logic [IDX_W-1:0] gain_to_idx(input logic signed [GAIN_W-1:0] g);
    logic signed [GAIN_W-1:0] sum;
    begin
      sum = g + GAIN_MAX;
      if (g < GAIN_MIN) begin
        gain_to_idx = '0;
      end else if (g > GAIN_MAX) begin
        gain_to_idx = IDX_W'(SCALE_DEPTH - 1);
      end else begin
        gain_to_idx = sum[IDX_W-1:0];
      end
    end
  endfunction

  // coefficient of one band
  function automatic logic [15:0] band_coef(input logic [BAND_W-1:0] band,
                                            input logic [IDX_W-1:0]  idx);
    begin
      if (band == REF_BAND) begin
        band_coef = DB_SCALE[idx];
      end else begin
        band_coef = DB_SCALE_LOW[idx];
      end
    end
  endfunction

  // private slot index of one band
  function automatic logic [15:0] band_slot(input logic [BAND_W-1:0] band);
    logic [7:0] slot;
    begin
      slot      = SLOT_BASE + SLOT_STRIDE * {{(8-BAND_W){1'b0}}, band};
      band_slot = {8'h00, slot};
    end
  endfunction

endpackage

>>> hdl/ceus_front.sv
// front end: takes requests, tracks eq state, classifies each into a job
module ceus_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [39:0] gain_band0..4 (8 bits each), [55:40] ctrl1_current, [71:56] ctrl2_current
  input  logic [71:0]         in_tdata,
  // [0] enable
  input  logic                in_tuser,
  input  logic                queue_full,
  output logic                push,
  output ceus_pkg::ceus_job_t push_job
);
  import ceus_pkg::*;

  logic                               eq_active_r;
  logic                               eq_active_nxt;
  logic [BANDS-1:0][GAIN_W-1:0]       applied_r;
  logic [BANDS-1:0][GAIN_W-1:0]       gains;
  logic [BANDS-1:0]                   mask;
  logic                               accept;

  assign in_tready = !queue_full;
  assign accept    = in_tvalid && in_tready;

  // unpack gains, find changed bands, clamp
  always_comb begin
    for (int b = 0; b < BANDS; b++) begin
      gains[b]              = in_tdata[b*GAIN_W +: GAIN_W];
      mask[b]               = !eq_active_r || (gains[b] != applied_r[b]);
      push_job.scale_idx[b] = gain_to_idx(gains[b]);
    end
    push_job.disable_eq = !in_tuser;
    push_job.activate   = !eq_active_r;
    push_job.band_mask  = mask;
    push_job.ctrl1      = in_tdata[BANDS*GAIN_W +: 16];
    push_job.ctrl2      = in_tdata[BANDS*GAIN_W+16 +: 16];
  end

  // an enable that changes nothing produces no job
  assign push = accept && (!in_tuser || (mask != '0));

  // next active flag
  always_comb begin
    eq_active_nxt = eq_active_r;
    if (accept) begin
      eq_active_nxt = in_tuser;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eq_active_r <= 1'b0;
    end else begin
      eq_active_r <= eq_active_nxt;
    end
  end

  // applied gains, written on every enable
  always_ff @(posedge clk) begin
    if (accept && in_tuser) begin
      applied_r <= gains;
    end
  end

endmodule

>>> hdl/ceus_fifo.sv
// short job queue between front end and sequencer
module ceus_fifo #(
  parameter int DEPTH = ceus_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ceus_pkg::ceus_job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output ceus_pkg::ceus_job_t head_job
);
  import ceus_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ceus_job_t          slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slots_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> hdl/ceus_back.sv
// back end: walks one job and issues its codec register writes one per cycle while the receiver takes them
module ceus_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                queue_empty,
  input  ceus_pkg::ceus_job_t head_job,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  // [7:0] reg_addr, [23:8] reg_value
  output logic [23:0]         out_tdata,
  output logic                out_tlast
);
  import ceus_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISABLE,
    S_BAND_IDX,
    S_BAND_DATA,
    S_STAGE_ON,
    S_LATCH_SET,
    S_LATCH_CLR
  } state_t;

  state_t             state_r;
  state_t             state_nxt;
  ceus_job_t          job_r;
  ceus_job_t          job_nxt;
  logic [BANDS-1:0]   mask_r;
  logic [BANDS-1:0]   mask_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [7:0]         out_addr_r;
  logic [7:0]         out_addr_nxt;
  logic [15:0]        out_value_r;
  logic [15:0]        out_value_nxt;
  logic               out_last_r;
  logic               out_last_nxt;
  logic               emit_ok;
  logic [BAND_W-1:0]  cur_band;
  logic [BANDS-1:0]   mask_left;
  logic [15:0]        ctrl1_clr;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_value_r, out_addr_r};
  assign out_tlast  = out_last_r;
  assign emit_ok    = !out_valid_r || out_tready;
  assign pop        = (state_r == S_IDLE) && !queue_empty;
  assign ctrl1_clr  = job_r.ctrl1 & ~BIT_ADC_SRC;

  // lowest band still to be written
  always_comb begin
    cur_band = '0;
    for (int b = BANDS - 1; b >= 0; b--) begin
      if (mask_r[b]) begin
        cur_band = BAND_W'(b);
      end
    end
    mask_left           = mask_r;
    mask_left[cur_band] = 1'b0;
  end

  // sequencer step
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_addr_nxt  = out_addr_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (!queue_empty) begin
          job_nxt  = head_job;
          mask_nxt = head_job.band_mask;
          if (head_job.disable_eq) begin
            state_nxt = S_DISABLE;
          end else if (head_job.band_mask != '0) begin
            state_nxt = S_BAND_IDX;
          end else begin
            state_nxt = S_LATCH_SET;
          end
        end
      end
      S_DISABLE: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = ADDR_CTRL2;
          out_value_nxt = job_r.ctrl2 & ~STAGE_BITS;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_BAND_IDX: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = ADDR_PRIV_INDEX;
          out_value_nxt = band_slot(cur_band);
          out_last_nxt  = 1'b0;
          state_nxt     = S_BAND_DATA;
        end
      end
      S_BAND_DATA: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = ADDR_PRIV_DATA;
          out_value_nxt = band_coef(cur_band, job_r.scale_idx[cur_band]);
          out_last_nxt  = 1'b0;
          mask_nxt      = mask_left;
          if (mask_left != '0) begin
            state_nxt = S_BAND_IDX;
          end else if (job_r.activate) begin
            state_nxt = S_STAGE_ON;
          end else begin
            state_nxt = S_LATCH_SET;
          end
        end
      end
      S_STAGE_ON: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = ADDR_CTRL2;
          out_value_nxt = (job_r.ctrl2 | STAGE_BITS) & ~BIT_LP_TYPE;
          out_last_nxt  = 1'b0;
          state_nxt     = S_LATCH_SET;
        end
      end
      S_LATCH_SET: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = ADDR_CTRL1;
          out_value_nxt = ctrl1_clr | BIT_LATCH;
          out_last_nxt  = 1'b0;
          state_nxt     = S_LATCH_CLR;
        end
      end
      S_LATCH_CLR: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = ADDR_CTRL1;
          out_value_nxt = ctrl1_clr;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      job_r       <= job_nxt;
      mask_r      <= mask_nxt;
      out_addr_r  <= out_addr_nxt;
      out_value_r <= out_value_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

endmodule

>>> hdl/codec_eq_update_sequencer.sv
// top level of the codec equaliser update sequencer
// One request word on the in_ channel carries the enable flag (tuser), five
// band gains and the present values of the two eq control registers (tdata).
// The block answers with a run of codec register writes on the out_ channel,
// one word per write, tlast on the final write of the run. A disable gives
// one write; an enable gives two writes per changed band (all five when the
// equaliser was off), a stage-enable write on activation and two latch
// writes, up to thirteen in all; an enable that changes nothing gives none.
// The front end classifies a request in the cycle it is accepted and pushes
// a job into a two-entry queue; the sequencer loads a job from the queue in
// its idle state, then issues one write per cycle while the receiver takes
// them, out_tvalid for the first write rising once the job has passed
// through the queue slot, the idle state and the output register. in_tready
// stays high while the queue has room.
// A stalled receiver holds the output register and the sequencer in place.
// After reset the equaliser counts as inactive and the queue is empty.
module codec_eq_update_sequencer #(
  parameter int QUEUE_DEPTH = ceus_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] gain_band0, [15:8] gain_band1, [23:16] gain_band2, [31:24] gain_band3,
  // [39:32] gain_band4, [55:40] ctrl1_current, [71:56] ctrl2_current
  input  logic [71:0] in_tdata,
  // [0] enable
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] reg_addr, [23:8] reg_value
  output logic [23:0] out_tdata,
  // last_write
  output logic        out_tlast
);
  import ceus_pkg::*;

  ceus_job_t push_job;
  ceus_job_t head_job;
  logic      push;
  logic      pop;
  logic      queue_full;
  logic      queue_empty;

  // request classification
  ceus_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  // job queue
  ceus_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head_job (head_job)
  );

  // write sequencer
  ceus_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .queue_empty (queue_empty),
    .head_job    (head_job),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
